@@ design/smsq_pkg.sv @@
// ----------------------------------------------------------------------------
// smsq_pkg
// Shared widths, constants, helper functions and divider types for the
// stepper move sequencer.
// ----------------------------------------------------------------------------
package smsq_pkg;

  localparam int MOVE_W    = 16;   // signed move count
  localparam int POS_W     = 12;   // rotor position, angle index
  localparam int SPR_W     = 13;   // steps_per_rev register
  localparam int RPM_W     = 10;   // rpm register
  localparam int ANG_W     = 25;   // Q16 angle
  localparam int COIL_W    = 4;
  localparam int PERIOD_W  = 26;   // step period and tick counter
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam int DIV_W     = 37;   // dividend / quotient width
  localparam int DVS_W     = 22;   // divisor width
  localparam int CNT_W     = $clog2(DIV_W);

  localparam logic [CNT_W-1:0]    DIV_CNT_LAST  = CNT_W'(DIV_W - 1);
  localparam logic [SPR_W-1:0]    MAX_SPR       = SPR_W'(4096);
  localparam logic [SPR_W-1:0]    SPR_RST       = SPR_W'(200);
  localparam logic [RPM_W-1:0]    RPM_RST       = RPM_W'(60);
  localparam logic [PERIOD_W-1:0] PERIOD_RST    = PERIOD_W'(5000);
  localparam logic [PERIOD_W-1:0] US_PER_MIN    = PERIOD_W'(60000000);
  localparam logic [ANG_W-1:0]    Q16_FULL_TURN = ANG_W'(23592960);

  // register indexes, paddr[3:2]
  localparam logic [1:0] REG_SPR = 2'd0;
  localparam logic [1:0] REG_RPM = 2'd1;
  localparam logic [1:0] REG_INV = 2'd2;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // full-step coil drive, bit0 = first pin
  function automatic logic [COIL_W-1:0] coil_of(input logic [1:0] phase);
    logic [COIL_W-1:0] c;
    unique case (phase)
      2'd0: c = 4'd5;
      2'd1: c = 4'd6;
      2'd2: c = 4'd10;
      2'd3: c = 4'd9;
      default: c = 4'd5;
    endcase
    return c;
  endfunction

  // one step up or down, modulo n; out-of-range values snap to an end
  function automatic logic [POS_W-1:0] wrap_step(input logic [POS_W-1:0] v,
                                                 input logic [SPR_W-1:0] n,
                                                 input logic up);
    logic [SPR_W-1:0] inc;
    logic [SPR_W-1:0] top;
    logic [POS_W-1:0] r;
    inc = {1'b0, v} + SPR_W'(1);
    top = n - SPR_W'(1);
    if (up) begin
      r = (inc >= n) ? '0 : inc[POS_W-1:0];
    end else if (v == '0 || {1'b0, v} >= n) begin
      r = top[POS_W-1:0];
    end else begin
      r = v - POS_W'(1);
    end
    return r;
  endfunction

endpackage

@@ design/smsq_in_if.sv @@
// ----------------------------------------------------------------------------
// smsq_in_if
// Input word channel: tick or move command.
// ----------------------------------------------------------------------------
interface smsq_in_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic signed [smsq_pkg::MOVE_W-1:0]  steps_to_move;

  modport source (output valid, output opcode, output steps_to_move, input ready);
  modport sink   (input valid, input opcode, input steps_to_move, output ready);
endinterface

@@ design/smsq_out_if.sv @@
// ----------------------------------------------------------------------------
// smsq_out_if
// Result word channel: one word per motor step.
// ----------------------------------------------------------------------------
interface smsq_out_if;
  logic                          valid;
  logic                          ready;
  logic [smsq_pkg::COIL_W-1:0]   coil_pattern;
  logic [smsq_pkg::POS_W-1:0]    rotor_position;
  logic [smsq_pkg::ANG_W-1:0]    angle_q16;
  logic                          move_done;

  modport source (output valid, output coil_pattern, output rotor_position,
                  output angle_q16, output move_done, input ready);
  modport sink   (input valid, input coil_pattern, input rotor_position,
                  input angle_q16, input move_done, output ready);
endinterface

@@ design/smsq_div.sv @@
// ----------------------------------------------------------------------------
// smsq_div
// Restoring divider, one quotient bit per cycle. A start restarts it.
// ----------------------------------------------------------------------------
module smsq_div (
  input  logic                clk,
  input  logic                rst_n,
  input  smsq_pkg::div_req_t  req,
  output smsq_pkg::div_rsp_t  rsp
);

  logic [smsq_pkg::DIV_W-1:0] dvd_r;
  logic [smsq_pkg::DVS_W-1:0] dsr_r;
  logic [smsq_pkg::DVS_W-1:0] rem_r;
  logic [smsq_pkg::CNT_W-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;

  logic [smsq_pkg::DVS_W:0]   rem_sh;
  logic [smsq_pkg::DVS_W:0]   rem_sub;
  logic                       ge;
  logic [smsq_pkg::DVS_W-1:0] rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[smsq_pkg::DIV_W-1]};
    rem_sub = rem_sh - {1'b0, dsr_r};
    ge      = (rem_sh >= {1'b0, dsr_r});
    rem_nxt = ge ? rem_sub[smsq_pkg::DVS_W-1:0] : rem_sh[smsq_pkg::DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + smsq_pkg::CNT_W'(1);
        if (cnt_r == smsq_pkg::DIV_CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[smsq_pkg::DIV_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule

@@ design/stepper_move_sequencer.sv @@
// ----------------------------------------------------------------------------
// stepper_move_sequencer
// Full-step four-phase stepper sequencer: microsecond ticks and signed move
// commands in, one coil/position/angle word out per motor step.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------
//  in_ch   | in  | valid/ready        | opcode, steps_to_move (s16)
//  out_ch  | out | valid/ready        | coil_pattern, rotor_position,
//          |     |                    | angle_q16, move_done
//  cfg     | in  | APB, pready tied 1 | steps_per_rev @0, rpm @4, invert @8
//
//  Sequence: a word that fires no step is handled in S_IDLE alone. A word that
//  fires a step goes through accept, divider start, one divide iteration per
//  quotient bit, quotient capture and result load on the shared bit-serial
//  divider. A config write while no move is pending and no step is in flight
//  recomputes the step period on the same divider: in_ch.ready stays low until
//  that divide is done after the last write, and in any write's access cycle.
//  Reset (sync, active low): registers 200 / 60 / 0, period 5000, all motion
//  state cleared; no divide pass is needed after reset.
//  A result waiting on out_ch does not block input; a new step waits in the
//  final state until the output register frees up.
// ----------------------------------------------------------------------------
module stepper_move_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  smsq_in_if.sink                         in_ch,
  smsq_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [smsq_pkg::PADDR_W-1:0]    paddr,
  input  logic [smsq_pkg::PDATA_W-1:0]    pwdata,
  output logic [smsq_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  typedef enum logic [2:0] {
    S_IDLE,   // ready for a word
    S_PMUL,   // start period divide: 60e6 / (n * rpm)
    S_PDIV,
    S_AMUL,   // start angle divide: index * 360 * 2^16 / n
    S_ADIV,
    S_OUT     // load result word when output register is free
  } state_t;

  state_t state_r;

  // config registers
  logic [smsq_pkg::SPR_W-1:0]    spr_r;
  logic [smsq_pkg::RPM_W-1:0]    rpm_r;
  logic                          inv_r;

  // motion state
  logic [smsq_pkg::POS_W-1:0]    position_r;
  logic [smsq_pkg::POS_W-1:0]    angle_index_r;
  logic [smsq_pkg::ANG_W-1:0]    angle_acc_r;
  logic [smsq_pkg::MOVE_W-1:0]   steps_left_r;
  logic [smsq_pkg::PERIOD_W-1:0] tick_count_r;
  logic [smsq_pkg::PERIOD_W-1:0] period_r;
  logic                          forward_r;

  // output register
  logic                          out_valid_r;
  logic [smsq_pkg::COIL_W-1:0]   coil_r;
  logic [smsq_pkg::POS_W-1:0]    rpos_r;
  logic [smsq_pkg::ANG_W-1:0]    ang_r;
  logic                          done_r;

  smsq_pkg::div_req_t div_req;
  smsq_pkg::div_rsp_t div_rsp;

  // combinational
  logic                          cfg_wr;
  logic                          cfg_take;
  logic [smsq_pkg::SPR_W-1:0]    n_eff;
  logic [smsq_pkg::RPM_W-1:0]    rpm_eff;
  logic [smsq_pkg::SPR_W+smsq_pkg::RPM_W-1:0] nr_prod;
  logic [smsq_pkg::DIV_W-1:0]    ang_prod;
  logic                          in_acc;
  logic                          out_free;
  logic                          moving;
  logic                          neg;
  logic [smsq_pkg::MOVE_W-1:0]   raw;
  logic [smsq_pkg::MOVE_W-1:0]   mag;
  logic [smsq_pkg::PERIOD_W-1:0] tick_nxt;
  logic                          fire;
  logic                          dir;
  logic [smsq_pkg::MOVE_W-1:0]   left_base;
  logic [smsq_pkg::POS_W-1:0]    pos_nxt;
  logic [smsq_pkg::POS_W-1:0]    aidx_nxt;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  // writes land only with no move pending; reserved index is dropped
  assign cfg_take = cfg_wr && (steps_left_r == '0) &&
                    (state_r == S_IDLE || state_r == S_PMUL || state_r == S_PDIV) &&
                    (paddr[3:2] == smsq_pkg::REG_SPR || paddr[3:2] == smsq_pkg::REG_RPM ||
                     paddr[3:2] == smsq_pkg::REG_INV);

  always_comb begin
    unique case (paddr[3:2])
      smsq_pkg::REG_SPR: prdata = smsq_pkg::PDATA_W'(spr_r);
      smsq_pkg::REG_RPM: prdata = smsq_pkg::PDATA_W'(rpm_r);
      smsq_pkg::REG_INV: prdata = smsq_pkg::PDATA_W'(inv_r);
      default:           prdata = '0;
    endcase
  end

  // clamp: zero counts as one, above the max counts as max
  always_comb begin
    priority if (spr_r == '0)               n_eff = smsq_pkg::SPR_W'(1);
    else if (spr_r > smsq_pkg::MAX_SPR)     n_eff = smsq_pkg::MAX_SPR;
    else                                    n_eff = spr_r;
    rpm_eff = (rpm_r == '0) ? smsq_pkg::RPM_W'(1) : rpm_r;
  end

  // two truncating divides collapse into one by the product
  assign nr_prod  = (smsq_pkg::SPR_W+smsq_pkg::RPM_W)'(n_eff) *
                    (smsq_pkg::SPR_W+smsq_pkg::RPM_W)'(rpm_eff);
  assign ang_prod = smsq_pkg::DIV_W'(angle_index_r) *
                    smsq_pkg::DIV_W'(smsq_pkg::Q16_FULL_TURN);

  always_comb begin
    div_req.start = (state_r == S_PMUL) || (state_r == S_AMUL);
    if (state_r == S_PMUL) begin
      div_req.dividend = smsq_pkg::DIV_W'(smsq_pkg::US_PER_MIN);
      div_req.divisor  = nr_prod[smsq_pkg::DVS_W-1:0];
    end else begin
      div_req.dividend = ang_prod;
      div_req.divisor  = smsq_pkg::DVS_W'(n_eff);
    end
  end

  smsq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // a config access cycle holds off input so the two never land together
  assign in_ch.ready = (state_r == S_IDLE) && !cfg_wr;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // step decision for the word at the input
  always_comb begin
    moving   = (steps_left_r != '0);
    raw      = in_ch.steps_to_move;
    neg      = raw[smsq_pkg::MOVE_W-1];
    mag      = neg ? (~raw + smsq_pkg::MOVE_W'(1)) : raw;  // -min maps to 2^(W-1)
    tick_nxt = tick_count_r + smsq_pkg::PERIOD_W'(1);
    if (in_ch.opcode) begin
      fire      = !moving && (mag != '0);
      dir       = !neg && (mag != '0);
      left_base = mag;
    end else begin
      fire      = moving && (tick_nxt >= period_r);
      dir       = forward_r;
      left_base = steps_left_r;
    end
    pos_nxt  = smsq_pkg::wrap_step(position_r, n_eff, dir);
    aidx_nxt = smsq_pkg::wrap_step(angle_index_r, n_eff, dir ^ inv_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      spr_r         <= smsq_pkg::SPR_RST;
      rpm_r         <= smsq_pkg::RPM_RST;
      inv_r         <= 1'b0;
      position_r    <= '0;
      angle_index_r <= '0;
      angle_acc_r   <= '0;
      steps_left_r  <= '0;
      tick_count_r  <= '0;
      period_r      <= smsq_pkg::PERIOD_RST;
      forward_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_take) begin
        unique case (paddr[3:2])
          smsq_pkg::REG_SPR: spr_r <= pwdata[smsq_pkg::SPR_W-1:0];
          smsq_pkg::REG_RPM: rpm_r <= pwdata[smsq_pkg::RPM_W-1:0];
          smsq_pkg::REG_INV: inv_r <= pwdata[0];
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (cfg_take) begin
            state_r <= S_PMUL;
          end else if (in_acc) begin
            if (in_ch.opcode && !moving) begin
              forward_r <= dir;
            end
            if (fire) begin
              position_r    <= pos_nxt;
              angle_index_r <= aidx_nxt;
              steps_left_r  <= left_base - smsq_pkg::MOVE_W'(1);
              tick_count_r  <= '0;
              state_r       <= S_AMUL;
            end else if (!in_ch.opcode && moving) begin
              tick_count_r <= tick_nxt;
            end
          end
        end
        S_PMUL: begin
          // a write landing here restarts the divide from the new value
          if (cfg_take) begin
            state_r <= S_PMUL;
          end else begin
            state_r <= S_PDIV;
          end
        end
        S_PDIV: begin
          // a fresh write restarts the period calculation
          if (cfg_take) begin
            state_r <= S_PMUL;
          end else if (div_rsp.done) begin
            period_r <= div_rsp.quotient[smsq_pkg::PERIOD_W-1:0];
            state_r  <= S_IDLE;
          end
        end
        S_AMUL: begin
          state_r <= S_ADIV;
        end
        S_ADIV: begin
          if (div_rsp.done) begin
            angle_acc_r <= div_rsp.quotient[smsq_pkg::ANG_W-1:0];
            state_r     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            coil_r      <= smsq_pkg::coil_of(position_r[1:0]);
            rpos_r      <= position_r;
            ang_r       <= angle_acc_r;
            done_r      <= (steps_left_r == '0);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.coil_pattern   = coil_r;
  assign out_ch.rotor_position = rpos_r;
  assign out_ch.angle_q16      = ang_r;
  assign out_ch.move_done      = done_r;

  // the divider is never mid-flight while input is taken
  a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !div_rsp.busy)
    else $error("input ready while divider busy");

  // angle quotient must stay below one full turn
  a_angle_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADIV && div_rsp.done) |=> (angle_acc_r < smsq_pkg::Q16_FULL_TURN))
    else $error("angle out of range");

  // during a move the rotor position lies within one revolution
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && steps_left_r != '0) |-> ({1'b0, position_r} < n_eff))
    else $error("rotor position beyond wrap");

  // a step result only loads into a free output register
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && !out_ch.ready) |=> (state_r == S_OUT))
    else $error("result dropped on stalled output");

endmodule
